// ===== sv/rsz_pkg.sv =====
// Shared types and constants for the image resampler.
// No dependencies; compiled first.
package rsz_pkg;

	localparam int FRAC_W  = 16;
	localparam int NUM_W   = 38;
	localparam int COORD_W = 12;
	localparam logic [NUM_W-1:0] HALF_Q = NUM_W'(32768);

	typedef enum logic [2:0] {
		CFG_SRC_W  = 3'd0,
		CFG_SRC_H  = 3'd1,
		CFG_TGT_W  = 3'd2,
		CFG_TGT_H  = 3'd3,
		CFG_CHAN   = 3'd4,
		CFG_MODE   = 3'd5
	} cfg_idx_t;

	typedef enum logic {
		FN_LOAD    = 1'b0,
		FN_REQUEST = 1'b1
	} func_t;

	typedef enum logic {
		MODE_NEAREST  = 1'b0,
		MODE_BILINEAR = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_MUL,
		F_DIV,
		F_FIN
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_READ,
		B_MUL,
		B_ACC
	} back_state_t;

	typedef struct packed {
		logic [8:0]  src_w;
		logic [8:0]  src_h;
		logic [12:0] tgt_w;
		logic [12:0] tgt_h;
		logic [2:0]  chan_cnt;
		logic        mode;
	} cfg_t;

	typedef struct packed {
		logic               is_load;
		logic [COORD_W-1:0] xa;
		logic [COORD_W-1:0] xb;
		logic [COORD_W-1:0] ya;
		logic [COORD_W-1:0] yb;
		logic [1:0]         ch;
		logic [FRAC_W-1:0]  fx;
		logic [FRAC_W-1:0]  fy;
		logic [7:0]         data;
	} entry_t;

	function automatic logic [COORD_W-1:0] clamp_coord(input logic [21:0] v,
		input logic [8:0] lim);
		logic [21:0] l;
		l = {13'd0, lim};
		clamp_coord = (v > l) ? COORD_W'(lim) : COORD_W'(v);
	endfunction

endpackage

// ===== sv/rsz_if.sv =====
// Handshake channel interfaces for the image resampler.
// Depends on nothing.
interface rsz_req_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [11:0] column;
	logic [11:0] row;
	logic [1:0]  channel;
	logic [7:0]  pixel_in;
	modport source (output valid, func, column, row, channel, pixel_in, input ready);
	modport sink   (input valid, func, column, row, channel, pixel_in, output ready);
endinterface

interface rsz_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_out;
	modport source (output valid, pixel_out, input ready);
	modport sink   (input valid, pixel_out, output ready);
endinterface

interface rsz_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [12:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/image_resampler.sv =====
// Image resampler top level: config registers, front, queue and back.
// Depends on rsz_pkg, rsz_if, rsz_front, rsz_queue, rsz_back.
//
//  port  dir   contents
//  req   in    func, column, row, channel, pixel_in
//  rsp   out   pixel_out
//  cfg   in    index, data (register write)
//
// A load is accepted and pushed in the same cycle and written by the back when it pops it.
// Before its result is raised, a request passes a multiply state, 38 divider steps, a push,
// a pop, four frame store reads on the single RAM port and the blend states B_MUL and B_ACC.
// The front takes no new item until it has pushed the result of a request.
// Reset clears control state only; the frame store holds no reset value.
// Front and back stall on their own through a two-entry queue; a held result blocks
// the next request in the back.
module image_resampler import rsz_pkg::*; #(
	parameter int MAX_WIDTH    = 256,
	parameter int MAX_HEIGHT   = 256,
	parameter int MAX_CHANNELS = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	rsz_req_if.sink   req,
	rsz_rsp_if.source rsp,
	rsz_cfg_if.sink   cfg
);
	cfg_t   cfg_q;
	logic   push, push_ready, pop, pop_valid;
	entry_t push_data, pop_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_w    <= 9'd256;
			cfg_q.src_h    <= 9'd256;
			cfg_q.tgt_w    <= 13'd256;
			cfg_q.tgt_h    <= 13'd256;
			cfg_q.chan_cnt <= 3'd3;
			cfg_q.mode     <= MODE_BILINEAR;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_SRC_W: cfg_q.src_w    <= cfg.data[8:0];
				CFG_SRC_H: cfg_q.src_h    <= cfg.data[8:0];
				CFG_TGT_W: cfg_q.tgt_w    <= cfg.data;
				CFG_TGT_H: cfg_q.tgt_h    <= cfg.data;
				CFG_CHAN:  cfg_q.chan_cnt <= cfg.data[2:0];
				CFG_MODE:  cfg_q.mode     <= cfg.data[0];
				default:   cfg_q          <= cfg_q;
			endcase
		end
	end

	rsz_front #(
		.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_CHANNELS(MAX_CHANNELS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.cfg        (cfg_q),
		.push       (push),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	rsz_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_data   (pop_data),
		.pop_valid  (pop_valid)
	);

	rsz_back #(
		.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_CHANNELS(MAX_CHANNELS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_data  (pop_data),
		.pop_valid (pop_valid),
		.pop       (pop),
		.rsp       (rsp)
	);
endmodule

// ===== sv/rsz_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module rsz_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 262144
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ===== sv/rsz_queue.sv =====
// Two-entry queue between front and back.
// Depends on rsz_pkg.
module rsz_queue import rsz_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_data,
	output logic   push_ready,
	input  logic   pop,
	output entry_t pop_data,
	output logic   pop_valid
);
	entry_t     slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_data;
	end

`ifndef SYNTH
	ap_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q != 2'd2)) else $error("queue overflow");
	ap_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (cnt_q != 2'd0)) else $error("queue underflow");
	ap_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1)) else $error("queue count");
`endif
endmodule

// ===== sv/rsz_front.sv =====
// Front: accepts items, checks loads, maps requests to source coordinates.
// Depends on rsz_pkg and rsz_if.
module rsz_front import rsz_pkg::*; #(
	parameter int MAX_WIDTH    = 256,
	parameter int MAX_HEIGHT   = 256,
	parameter int MAX_CHANNELS = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	rsz_req_if.sink   req,
	input  cfg_t      cfg,
	output logic      push,
	output entry_t    push_data,
	input  logic      push_ready
);
	localparam int CNT_W = $clog2(NUM_W);

	front_state_t       state_q, state_d;
	logic [COORD_W-1:0] col_q, row_q;
	logic [1:0]         ch_q;
	logic [NUM_W-1:0]   numx_q, numy_q, qx_q, qy_q;
	logic [13:0]        remx_q, remy_q;
	logic [CNT_W-1:0]   cnt_q;

	logic [8:0]  swe, she;
	logic [12:0] twe, the;
	logic [2:0]  cce, ch3;
	logic [13:0] dx, dy;
	logic [14:0] rx_sh, ry_sh;
	logic        bx, by;
	logic        accept, load_ok;
	logic [21:0] prodx, prody;
	logic [NUM_W-1:0] tx, ty;
	logic [21:0] hx, hy;
	entry_t      req_ent, load_ent;

	always_comb begin
		swe = (cfg.src_w == 9'd0) ? 9'd1 :
			(13'(cfg.src_w) > 13'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : cfg.src_w;
		she = (cfg.src_h == 9'd0) ? 9'd1 :
			(13'(cfg.src_h) > 13'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : cfg.src_h;
		twe = (cfg.tgt_w == 13'd0) ? 13'd1 : cfg.tgt_w;
		the = (cfg.tgt_h == 13'd0) ? 13'd1 : cfg.tgt_h;
		cce = (cfg.chan_cnt == 3'd0) ? 3'd1 :
			(cfg.chan_cnt > 3'(MAX_CHANNELS)) ? 3'(MAX_CHANNELS) : cfg.chan_cnt;
		ch3 = {1'b0, req.channel};
		dx  = {twe, 1'b0};
		dy  = {the, 1'b0};
	end

	assign accept  = req.valid && req.ready;
	assign load_ok = (13'(req.column) < 13'(MAX_WIDTH)) && (13'(req.row) < 13'(MAX_HEIGHT))
		&& (ch3 < 3'(MAX_CHANNELS));

	assign prodx = 22'({col_q, 1'b1}) * 22'(swe);
	assign prody = 22'({row_q, 1'b1}) * 22'(she);

	assign rx_sh = {remx_q, numx_q[NUM_W-1]};
	assign ry_sh = {remy_q, numy_q[NUM_W-1]};
	assign bx    = (rx_sh >= 15'(dx));
	assign by    = (ry_sh >= 15'(dy));

	assign tx = qx_q + HALF_Q;
	assign ty = qy_q + HALF_Q;
	assign hx = tx[NUM_W-1:FRAC_W];
	assign hy = ty[NUM_W-1:FRAC_W];

	always_comb begin
		req_ent         = '0;
		req_ent.is_load = 1'b0;
		req_ent.ch      = ch_q;
		if (cfg.mode == MODE_NEAREST) begin
			req_ent.xa = clamp_coord(qx_q[NUM_W-1:FRAC_W], swe - 9'd1);
			req_ent.xb = req_ent.xa;
			req_ent.ya = clamp_coord(qy_q[NUM_W-1:FRAC_W], she - 9'd1);
			req_ent.yb = req_ent.ya;
		end else begin
			req_ent.xb = clamp_coord(hx, swe - 9'd1);
			req_ent.xa = (hx == 22'd0) ? '0 : clamp_coord(hx - 22'd1, swe - 9'd1);
			req_ent.yb = clamp_coord(hy, she - 9'd1);
			req_ent.ya = (hy == 22'd0) ? '0 : clamp_coord(hy - 22'd1, she - 9'd1);
			req_ent.fx = tx[FRAC_W-1:0];
			req_ent.fy = ty[FRAC_W-1:0];
		end
	end

	always_comb begin
		load_ent         = '0;
		load_ent.is_load = 1'b1;
		load_ent.xa      = req.column;
		load_ent.ya      = req.row;
		load_ent.ch      = req.channel;
		load_ent.data    = req.pixel_in;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: if (accept && req.func == FN_REQUEST) state_d = F_MUL;
			F_MUL:  state_d = F_DIV;
			F_DIV:  if (cnt_q == CNT_W'(NUM_W - 1)) state_d = F_FIN;
			F_FIN:  if (push_ready) state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		push      = 1'b0;
		push_data = load_ent;
		case (state_q)
			F_IDLE: begin
				req.ready = push_ready;
				push      = accept && (req.func == FN_LOAD) && load_ok;
			end
			F_FIN: begin
				push      = push_ready;
				push_data = req_ent;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				col_q <= req.column;
				row_q <= req.row;
				ch_q  <= (ch3 >= cce) ? 2'(cce - 3'd1) : req.channel;
			end
			F_MUL: begin
				numx_q <= {prodx, 16'd0};
				numy_q <= {prody, 16'd0};
				remx_q <= '0;
				remy_q <= '0;
				cnt_q  <= '0;
			end
			F_DIV: begin
				numx_q <= numx_q << 1;
				numy_q <= numy_q << 1;
				remx_q <= bx ? 14'(rx_sh - 15'(dx)) : rx_sh[13:0];
				remy_q <= by ? 14'(ry_sh - 15'(dy)) : ry_sh[13:0];
				qx_q   <= {qx_q[NUM_W-2:0], bx};
				qy_q   <= {qy_q[NUM_W-2:0], by};
				cnt_q  <= cnt_q + CNT_W'(1);
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end
endmodule

// ===== sv/rsz_back.sv =====
// Back: writes loads to the frame store, reads four neighbors and blends them.
// Depends on rsz_pkg, rsz_if and rsz_ram.
module rsz_back import rsz_pkg::*; #(
	parameter int MAX_WIDTH    = 256,
	parameter int MAX_HEIGHT   = 256,
	parameter int MAX_CHANNELS = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  entry_t   pop_data,
	input  logic     pop_valid,
	output logic     pop,
	rsz_rsp_if.source rsp
);
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
	localparam int AW    = $clog2(DEPTH);

	back_state_t state_q, state_d;
	entry_t      ent_q;
	logic [1:0]  cnt_q;
	logic [33:0] w_s1;
	logic        vld_s1, vld_s2;
	logic [39:0] prod_s2;
	logic [39:0] acc_q, acc_d;
	logic        out_vld_q;
	logic [7:0]  out_q;

	logic               we;
	logic [AW-1:0]      addr;
	logic [COORD_W-1:0] ax, ay;
	logic [1:0]         ac;
	logic [7:0]         wdata, rdata;
	logic [16:0]        wx0, wy0, wa, wb;
	logic [40:0]        rnd;

	assign pop = pop_valid && (state_q == B_IDLE) && (pop_data.is_load || !out_vld_q);
	assign we  = pop && pop_data.is_load;

	always_comb begin
		if (state_q == B_IDLE) begin
			ax    = pop_data.xa;
			ay    = pop_data.ya;
			ac    = pop_data.ch;
		end else begin
			ax    = cnt_q[0] ? ent_q.xb : ent_q.xa;
			ay    = cnt_q[1] ? ent_q.yb : ent_q.ya;
			ac    = ent_q.ch;
		end
		wdata = pop_data.data;
		addr  = AW'((32'(ay) * 32'(MAX_WIDTH) + 32'(ax)) * 32'(MAX_CHANNELS) + 32'(ac));
	end

	rsz_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (we),
		.addr  (addr),
		.wdata (wdata),
		.rdata (rdata)
	);

	always_comb begin
		wx0 = 17'h10000 - {1'b0, ent_q.fx};
		wy0 = 17'h10000 - {1'b0, ent_q.fy};
		wa  = cnt_q[0] ? {1'b0, ent_q.fx} : wx0;
		wb  = cnt_q[1] ? {1'b0, ent_q.fy} : wy0;
		acc_d = vld_s2 ? acc_q + prod_s2 : acc_q;
		rnd   = {1'b0, acc_d} + 41'h0080000000;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: if (pop && !pop_data.is_load) state_d = B_READ;
			B_READ: if (cnt_q == 2'd3) state_d = B_MUL;
			B_MUL:  state_d = B_ACC;
			B_ACC:  state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	assign rsp.valid     = out_vld_q;
	assign rsp.pixel_out = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			out_vld_q <= 1'b0;
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			cnt_q     <= 2'd0;
		end else begin
			state_q <= state_d;
			vld_s1  <= (state_q == B_READ);
			vld_s2  <= vld_s1;
			cnt_q   <= (state_q == B_READ) ? cnt_q + 2'd1 : 2'd0;
			if (state_q == B_ACC) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		w_s1    <= 34'(wa) * 34'(wb);
		prod_s2 <= 40'(rdata) * 40'(w_s1);
		if (state_q == B_IDLE) begin
			ent_q <= pop_data;
			acc_q <= '0;
		end else begin
			acc_q <= acc_d;
		end
		if (state_q == B_ACC) begin
			out_q <= rnd[40] ? 8'hFF : rnd[39:32];
		end
	end

`ifndef SYNTH
	ap_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == B_IDLE)) else $error("pop while busy");
	ap_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_READ) |-> !out_vld_q) else $error("result slot taken");
	ap_out_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> ($past(state_q) == B_ACC)) else $error("spurious result");
`endif
endmodule
